FILE: hdl/steering_direction_unit_top_macros.svh
// Assertion macros for the steering direction unit.
`ifndef STEERING_DIRECTION_UNIT_TOP_MACROS_SVH
`define STEERING_DIRECTION_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdu assertion failed");

// Next-cycle implication, disabled during reset.
`define SDU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdu assertion failed");

`endif

FILE: hdl/sdu_pkg.sv
// Shared types and constants of the steering direction unit.
package sdu_pkg;

  localparam int CoordW = 32;
  localparam int LatW   = 16;
  localparam int RadW   = 32;
  localparam int DirW   = 16;
  localparam int CmdW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW   = 32;

  localparam logic [CmdW-1:0] CMD_SEEK     = 3'd0;
  localparam logic [CmdW-1:0] CMD_FLEE     = 3'd1;
  localparam logic [CmdW-1:0] CMD_PURSUE   = 3'd2;
  localparam logic [CmdW-1:0] CMD_EVADE    = 3'd3;
  localparam logic [CmdW-1:0] CMD_APPROACH = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_LOOK_AHEAD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OUTER      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INNER      = 2'd2;

  localparam logic [LatW-1:0] LOOK_AHEAD_RST = 16'd256;
  localparam logic [RadW-1:0] OUTER_RST      = 32'd2560;
  localparam logic [RadW-1:0] INNER_RST      = 32'd1280;

  localparam int QueueDepthDef = 2;

  // Command class made by the front end.
  typedef struct packed {
    logic known;     // command 0..4
    logic toward;    // seek or pursue
    logic lead;      // pursue or evade: move target ahead
    logic approach;  // hysteresis command
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [CoordW-1:0] own_x;
    logic signed [CoordW-1:0] own_y;
    logic signed [CoordW-1:0] own_z;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic signed [CoordW-1:0] target_z;
    logic signed [CoordW-1:0] target_vel_x;
    logic signed [CoordW-1:0] target_vel_z;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAD,
    ST_DIST,
    ST_DIFF,
    ST_SCALE,
    ST_SQ,
    ST_SQRT,
    ST_DIVINIT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/sdu_front.sv
// Front end: command decode and the item queue feeding the back end.
module sdu_front #(
  parameter int DEPTH = sdu_pkg::QueueDepthDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [sdu_pkg::CmdW-1:0]          command,
  input  logic signed [sdu_pkg::CoordW-1:0] own_x,
  input  logic signed [sdu_pkg::CoordW-1:0] own_y,
  input  logic signed [sdu_pkg::CoordW-1:0] own_z,
  input  logic signed [sdu_pkg::CoordW-1:0] target_x,
  input  logic signed [sdu_pkg::CoordW-1:0] target_y,
  input  logic signed [sdu_pkg::CoordW-1:0] target_z,
  input  logic signed [sdu_pkg::CoordW-1:0] target_vel_x,
  input  logic signed [sdu_pkg::CoordW-1:0] target_vel_z,
  output sdu_pkg::item_t                    q_item,
  output logic                              q_avail,
  input  logic                              q_pop
);
  import sdu_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  kind_t           kind;
  item_t           in_item;
  logic            wr_en;
  logic            rd_en;

  always_comb begin
    kind = '0;
    case (command)
      CMD_SEEK:     kind = '{known: 1'b1, toward: 1'b1, lead: 1'b0, approach: 1'b0};
      CMD_FLEE:     kind = '{known: 1'b1, toward: 1'b0, lead: 1'b0, approach: 1'b0};
      CMD_PURSUE:   kind = '{known: 1'b1, toward: 1'b1, lead: 1'b1, approach: 1'b0};
      CMD_EVADE:    kind = '{known: 1'b1, toward: 1'b0, lead: 1'b1, approach: 1'b0};
      CMD_APPROACH: kind = '{known: 1'b1, toward: 1'b0, lead: 1'b0, approach: 1'b1};
      default:      kind = '0;
    endcase
  end

  always_comb begin
    in_item.kind         = kind;
    in_item.own_x        = own_x;
    in_item.own_y        = own_y;
    in_item.own_z        = own_z;
    in_item.target_x     = target_x;
    in_item.target_y     = target_y;
    in_item.target_z     = target_z;
    in_item.target_vel_x = target_vel_x;
    in_item.target_vel_z = target_vel_z;
  end

  assign full    = (count == CntW'(DEPTH));
  assign q_avail = (count != '0);
  assign q_item  = mem[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_avail;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/sdu_back.sv
// Back end: look-ahead, hysteresis, scaling, square root, divide, result register.
module sdu_back (
  input  logic                              clk,
  input  logic                              rst,
  input  sdu_pkg::item_t                    q_item,
  input  logic                              q_avail,
  output logic                              q_pop,
  input  logic [sdu_pkg::LatW-1:0]          look_ahead_time,
  input  logic [sdu_pkg::RadW-1:0]          outer_radius,
  input  logic [sdu_pkg::RadW-1:0]          inner_radius,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [sdu_pkg::DirW-1:0]   dir_x,
  output logic signed [sdu_pkg::DirW-1:0]   dir_y,
  output logic signed [sdu_pkg::DirW-1:0]   dir_z,
  output logic                              degenerate,
  output logic                              seeking
);
  import sdu_pkg::*;

  state_t state;
  state_t state_next;
  logic [4:0] cnt;

  kind_t              kind;
  logic signed [31:0] own [3];
  logic signed [40:0] tgt [3];
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_z;
  logic               toward;
  logic               seek;
  logic               ge_outer;
  logic               degen;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;
  logic [65:0]        acc;

  logic [41:0]        mag [3];
  logic               neg [3];
  logic signed [41:0] dvec [3];
  logic signed [41:0] vsel [3];

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] sbit;
  logic [63:0] rem_cur;
  logic [63:0] res_cur;
  logic [63:0] bit_cur;
  logic [63:0] trial;

  logic [46:0] dnum [3];
  logic [46:0] dden;
  logic [15:0] quo [3];
  logic [14:0] qc [3];

  logic all_zero;
  logic too_wide;
  logic res_we;

  logic               out_valid;
  logic signed [15:0] rdir [3];
  logic               rdeg;
  logic               rseek;

  // difference target minus agent, then negated when not moving toward (flee, evade, approach away)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvec[i] = 42'(tgt[i]) - 42'(own[i]);
      vsel[i] = toward ? dvec[i] : -dvec[i];
    end
  end

  assign all_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  assign too_wide = (|mag[0][41:31]) || (|mag[1][41:31]) || (|mag[2][41:31]);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LEAD: begin
        mul_a = (cnt == 5'd0) ? 34'(vel_x) : 34'(vel_z);
        mul_b = {18'b0, look_ahead_time};
      end
      ST_DIST: begin
        case (cnt)
          5'd0:    begin mul_a = dvec[0][33:0]; mul_b = dvec[0][33:0]; end
          5'd1:    begin mul_a = dvec[1][33:0]; mul_b = dvec[1][33:0]; end
          5'd2:    begin mul_a = dvec[2][33:0]; mul_b = dvec[2][33:0]; end
          5'd3:    begin mul_a = {2'b0, outer_radius}; mul_b = {2'b0, outer_radius}; end
          default: begin mul_a = {2'b0, inner_radius}; mul_b = {2'b0, inner_radius}; end
        endcase
      end
      ST_SQ: begin
        case (cnt)
          5'd0:    begin mul_a = {3'b0, mag[0][30:0]}; mul_b = {3'b0, mag[0][30:0]}; end
          5'd1:    begin mul_a = {3'b0, mag[1][30:0]}; mul_b = {3'b0, mag[1][30:0]}; end
          default: begin mul_a = {3'b0, mag[2][30:0]}; mul_b = {3'b0, mag[2][30:0]}; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root step operands
  always_comb begin
    rem_cur = (cnt == 5'd0) ? acc[63:0] : rem;
    res_cur = (cnt == 5'd0) ? '0 : res;
    bit_cur = (cnt == 5'd0) ? 64'h4000_0000_0000_0000 : sbit;
    trial   = res_cur + bit_cur;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    res_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_avail) begin
          q_pop = 1'b1;
          if (!q_item.kind.known) begin
            state_next = ST_DONE;
          end else if (q_item.kind.lead) begin
            state_next = ST_LEAD;
          end else if (q_item.kind.approach) begin
            state_next = ST_DIST;
          end else begin
            state_next = ST_DIFF;
          end
        end
      end
      ST_LEAD:    if (cnt == 5'd2) state_next = ST_DIFF;
      ST_DIST:    if (cnt == 5'd5) state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_SCALE;
      ST_SCALE: begin
        if (all_zero) begin
          state_next = ST_DONE;
        end else if (!too_wide) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ:      if (cnt == 5'd3) state_next = ST_SQRT;
      ST_SQRT:    if (cnt == 5'd31) state_next = ST_DIVINIT;
      ST_DIVINIT: state_next = ST_DIV;
      ST_DIV:     if (cnt == 5'd15) state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || pop) begin
          res_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seek <= 1'b0;
    end else if (state == ST_DIST && cnt == 5'd5) begin
      if (ge_outer) begin
        seek <= 1'b1;
      end else if (acc <= {2'b0, prod[63:0]}) begin
        seek <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (q_avail) begin
          kind   <= q_item.kind;
          toward <= q_item.kind.toward;
          degen  <= 1'b0;
          own[0] <= q_item.own_x;
          own[1] <= q_item.own_y;
          own[2] <= q_item.own_z;
          tgt[0] <= 41'(q_item.target_x);
          tgt[1] <= 41'(q_item.target_y);
          tgt[2] <= 41'(q_item.target_z);
          vel_x  <= q_item.target_vel_x;
          vel_z  <= q_item.target_vel_z;
        end
      end
      ST_LEAD: begin
        // arithmetic shift floors the Q.8 offset
        if (cnt == 5'd1) tgt[0] <= tgt[0] + prod[48:8];
        if (cnt == 5'd2) tgt[2] <= tgt[2] + prod[48:8];
      end
      ST_DIST: begin
        case (cnt)
          5'd0:    acc <= '0;
          5'd1, 5'd2, 5'd3: acc <= acc + prod[65:0];
          5'd4:    ge_outer <= (acc >= {2'b0, prod[63:0]});
          default: begin
            if (ge_outer) begin
              toward <= 1'b1;
            end else if (acc <= {2'b0, prod[63:0]}) begin
              toward <= 1'b0;
            end else begin
              toward <= seek;
            end
          end
        endcase
      end
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vsel[i][41];
          mag[i] <= vsel[i][41] ? 42'(-vsel[i]) : 42'(vsel[i]);
        end
      end
      ST_SCALE: begin
        if (all_zero) begin
          degen <= 1'b1;
        end else if (too_wide) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end
      end
      ST_SQ: begin
        if (cnt == 5'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + prod[65:0];
        end
      end
      ST_SQRT: begin
        if (rem_cur >= trial) begin
          rem <= rem_cur - trial;
          res <= (res_cur >> 1) + bit_cur;
        end else begin
          rem <= rem_cur;
          res <= res_cur >> 1;
        end
        sbit <= bit_cur >> 2;
      end
      ST_DIVINIT: begin
        for (int i = 0; i < 3; i++) begin
          dnum[i] <= {1'b0, mag[i][30:0], 15'b0} + {16'b0, res[31:1]};
          quo[i]  <= '0;
        end
        dden <= {res[31:0], 15'b0};
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (dnum[i] >= dden) begin
            dnum[i] <= dnum[i] - dden;
            quo[i]  <= {quo[i][14:0], 1'b1};
          end else begin
            quo[i]  <= {quo[i][14:0], 1'b0};
          end
        end
        dden <= dden >> 1;
      end
      default: begin
      end
    endcase
  end

  // clamp 32768 to 32767
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = quo[i][15] ? 15'h7fff : quo[i][14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_we) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      for (int i = 0; i < 3; i++) begin
        if (!kind.known || degen) begin
          rdir[i] <= '0;
        end else begin
          rdir[i] <= neg[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
        end
      end
      rdeg  <= kind.known && degen;
      rseek <= seek;
    end
  end

  assign empty      = !out_valid;
  assign dir_x      = rdir[0];
  assign dir_y      = rdir[1];
  assign dir_z      = rdir[2];
  assign degenerate = rdeg;
  assign seeking    = rseek;

endmodule

FILE: hdl/steering_direction_unit_top.sv
// Top level of the steering direction unit: config registers, front and back ends.
//
//   channel   handshake         payload
//   input     push / full       command, own_x/y/z, target_x/y/z, target_vel_x/z
//   result    empty / pop       dir_x/y/z, degenerate, seeking
//   config    cfg_we            cfg_index, cfg_data
//
// The back end works through each item with a 32-step square root
// and a 16-step divider (three lanes in parallel).
// Zero vectors and unknown commands skip the square root and divider.
// Reset is synchronous on rst; it empties the queue and clears the approach flag.
// The input queue keeps taking items while the back end works or the result waits.
`include "steering_direction_unit_top_macros.svh"

module steering_direction_unit_top #(
  parameter int QUEUE_DEPTH = sdu_pkg::QueueDepthDef
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [sdu_pkg::CmdW-1:0]            command,
  input  logic signed [sdu_pkg::CoordW-1:0]   own_x,
  input  logic signed [sdu_pkg::CoordW-1:0]   own_y,
  input  logic signed [sdu_pkg::CoordW-1:0]   own_z,
  input  logic signed [sdu_pkg::CoordW-1:0]   target_x,
  input  logic signed [sdu_pkg::CoordW-1:0]   target_y,
  input  logic signed [sdu_pkg::CoordW-1:0]   target_z,
  input  logic signed [sdu_pkg::CoordW-1:0]   target_vel_x,
  input  logic signed [sdu_pkg::CoordW-1:0]   target_vel_z,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [sdu_pkg::DirW-1:0]     dir_x,
  output logic signed [sdu_pkg::DirW-1:0]     dir_y,
  output logic signed [sdu_pkg::DirW-1:0]     dir_z,
  output logic                                degenerate,
  output logic                                seeking,
  input  logic                                cfg_we,
  input  logic [sdu_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [sdu_pkg::CfgW-1:0]            cfg_data
);
  import sdu_pkg::*;

  logic [LatW-1:0] look_ahead_time;
  logic [RadW-1:0] outer_radius;
  logic [RadW-1:0] inner_radius;

  item_t q_item;
  logic  q_avail;
  logic  q_pop;

  // Config registers; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      look_ahead_time <= LOOK_AHEAD_RST;
      outer_radius    <= OUTER_RST;
      inner_radius    <= INNER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOOK_AHEAD: look_ahead_time <= cfg_data[LatW-1:0];
        CFG_OUTER:      outer_radius    <= cfg_data[RadW-1:0];
        CFG_INNER:      inner_radius    <= cfg_data[RadW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: decode the command and queue the item.
  sdu_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .own_x        (own_x),
    .own_y        (own_y),
    .own_z        (own_z),
    .target_x     (target_x),
    .target_y     (target_y),
    .target_z     (target_z),
    .target_vel_x (target_vel_x),
    .target_vel_z (target_vel_z),
    .q_item       (q_item),
    .q_avail      (q_avail),
    .q_pop        (q_pop)
  );

  // Back end: sequencer over the shared multiplier, root and divider.
  sdu_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_item          (q_item),
    .q_avail         (q_avail),
    .q_pop           (q_pop),
    .look_ahead_time (look_ahead_time),
    .outer_radius    (outer_radius),
    .inner_radius    (inner_radius),
    .empty           (empty),
    .pop             (pop),
    .dir_x           (dir_x),
    .dir_y           (dir_y),
    .dir_z           (dir_z),
    .degenerate      (degenerate),
    .seeking         (seeking)
  );

  // A degenerate result carries a zero direction.
  `SDU_ASSERT_IMP(a_degen_zero, !empty && degenerate, dir_x == 0 && dir_y == 0 && dir_z == 0)
  // Clamping keeps every component off the most negative code.
  `SDU_ASSERT_IMP(a_dir_range, !empty, dir_x != -16'sd32768 && dir_y != -16'sd32768 && dir_z != -16'sd32768)
  // An accepted item is in the queue in the next cycle.
  `SDU_ASSERT_NXT(a_push_lands, push && !full, q_avail)

endmodule
